>>> sv/multichannel_moving_average_core_assert.svh
// Assertion macros for the moving-average core.
// Needs clk and rst_n in the scope of the module that includes it.
`ifndef MULTICHANNEL_MOVING_AVERAGE_CORE_ASSERT_SVH
`define MULTICHANNEL_MOVING_AVERAGE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MMA_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mma_pkg.sv
// Shared constants, types and the reciprocal table of the moving-average core.
// No dependencies.
package mma_pkg;

    localparam int CHANNELS     = 8;
    localparam int SAMPLE_BITS  = 16;
    localparam int MAX_WINDOW   = 32;
    localparam int SLOT_BITS    = 5;
    localparam int WIN_BITS     = 6;
    localparam int SUM_BITS     = SAMPLE_BITS + SLOT_BITS;
    localparam int RECIP_SHIFT  = SUM_BITS;
    localparam int RECIP_BITS   = RECIP_SHIFT + 1;

    localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(20);

    typedef logic signed [SAMPLE_BITS-1:0]         sample_t;
    typedef logic signed [SUM_BITS-1:0]            sum_t;
    typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  frame_t;

    typedef struct packed {
        logic                start;
        logic [WIN_BITS-1:0] divisor;
    } div_req_t;

    // floor(2^RECIP_SHIFT / d), entry d-1 for d = 1..32
    localparam logic [RECIP_BITS-1:0] RECIP_TABLE [MAX_WINDOW] = '{
        22'd2097152, 22'd1048576, 22'd699050, 22'd524288,
        22'd419430,  22'd349525,  22'd299593, 22'd262144,
        22'd233016,  22'd209715,  22'd190650, 22'd174762,
        22'd161319,  22'd149796,  22'd139810, 22'd131072,
        22'd123361,  22'd116508,  22'd110376, 22'd104857,
        22'd99864,   22'd95325,   22'd91180,  22'd87381,
        22'd83886,   22'd80659,   22'd77672,  22'd74898,
        22'd72315,   22'd69905,   22'd67650,  22'd65536
    };

    function automatic sum_t sext_sample(input logic [SAMPLE_BITS-1:0] s);
        return {{(SUM_BITS-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
    endfunction

endpackage

>>> sv/mma_div.sv
// Eight-lane signed divider by a small frame count (1..32), three stages.
// Reciprocal multiply with one correction step; depends on mma_pkg.
module mma_div
    import mma_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    input  sum_t     sums [CHANNELS],
    output logic     done,
    output sample_t  quot [CHANNELS]
);

    localparam int MAG_BITS  = SUM_BITS;
    localparam int PROD_BITS = MAG_BITS + RECIP_BITS;
    localparam int QD_BITS   = MAG_BITS + WIN_BITS;

    logic v1_reg, v2_reg, v3_reg;
    logic [WIN_BITS-1:0] d1_reg, d2_reg;
    logic [MAG_BITS-1:0] mag1_reg [CHANNELS];
    logic [MAG_BITS-1:0] mag2_reg [CHANNELS];
    logic [MAG_BITS-1:0] q0_reg   [CHANNELS];
    logic                neg1_reg [CHANNELS];
    logic                neg2_reg [CHANNELS];
    sample_t             quot_reg [CHANNELS];
    logic [RECIP_BITS-1:0] recip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign recip = RECIP_TABLE[SLOT_BITS'(d1_reg - WIN_BITS'(1))];

    always_ff @(posedge clk)
    begin
        if (req.start)
            d1_reg <= req.divisor;
        if (v1_reg)
            d2_reg <= d1_reg;
    end

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        logic [PROD_BITS-1:0] prod;
        logic [QD_BITS-1:0]   qd;
        logic [QD_BITS-1:0]   rem;
        logic [MAG_BITS-1:0]  q_fix;
        logic [MAG_BITS-1:0]  q_signed;

        assign prod     = PROD_BITS'(mag1_reg[c]) * PROD_BITS'(recip);
        assign qd       = QD_BITS'(q0_reg[c]) * QD_BITS'(d2_reg);
        assign rem      = QD_BITS'(mag2_reg[c]) - qd;
        // estimate is at most one short
        assign q_fix    = (rem >= QD_BITS'(d2_reg)) ? q0_reg[c] + MAG_BITS'(1) : q0_reg[c];
        assign q_signed = neg2_reg[c] ? -q_fix : q_fix;

        always_ff @(posedge clk)
        begin
            if (req.start)
            begin
                neg1_reg[c] <= sums[c][SUM_BITS-1];
                mag1_reg[c] <= sums[c][SUM_BITS-1] ? MAG_BITS'(-sums[c])
                                                   : MAG_BITS'(sums[c]);
            end
            if (v1_reg)
            begin
                neg2_reg[c] <= neg1_reg[c];
                mag2_reg[c] <= mag1_reg[c];
                q0_reg[c]   <= prod[RECIP_SHIFT +: MAG_BITS];
            end
            if (v2_reg)
                quot_reg[c] <= q_signed[SAMPLE_BITS-1:0];
        end
    end

    assign done = v3_reg;
    assign quot = quot_reg;

endmodule

>>> sv/multichannel_moving_average_core.sv
// Top level of the eight-channel sliding-window moving average.
// Depends on mma_pkg, mma_div and multichannel_moving_average_core_assert.svh.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------
//   in      | in_valid/in_ready   | ch0_sample .. ch7_sample
//   out     | out_valid/out_ready | ch0_average .. ch7_average
//   cfg     | cfg_write_en        | cfg_write_data (window_length)
//
// Per frame: a ring read at the transfer, a ring write and sum update, three divider
// stages, then an output load; the next input transfer waits until that load.
// A result still waiting at the output blocks the divider hand-off to the output and
// with it the next input transfer.
// Reset is asynchronous, active low; the ring needs no clearing pass.
`include "multichannel_moving_average_core_assert.svh"

module multichannel_moving_average_core
    import mma_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sample_t             ch0_sample,
    input  sample_t             ch1_sample,
    input  sample_t             ch2_sample,
    input  sample_t             ch3_sample,
    input  sample_t             ch4_sample,
    input  sample_t             ch5_sample,
    input  sample_t             ch6_sample,
    input  sample_t             ch7_sample,
    output logic                out_valid,
    input  logic                out_ready,
    output sample_t             ch0_average,
    output sample_t             ch1_average,
    output sample_t             ch2_average,
    output sample_t             ch3_average,
    output sample_t             ch4_average,
    output sample_t             ch5_average,
    output sample_t             ch6_average,
    output sample_t             ch7_average,
    input  logic                cfg_write_en,
    input  logic [WIN_BITS-1:0] cfg_write_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_UPDATE, ST_DIVIDE, ST_DELIVER} state_t;

    state_t               state_reg;
    logic [WIN_BITS-1:0]  window_reg;
    logic [WIN_BITS-1:0]  frames_held_reg;
    logic [SLOT_BITS-1:0] oldest_reg;
    logic                 full_reg;
    logic                 out_valid_reg;
    div_req_t             div_req_reg;

    logic [SLOT_BITS-1:0] slot_reg;
    frame_t               sample_reg;
    frame_t               ring_rd_reg;
    frame_t               ring_mem [MAX_WINDOW];
    sum_t                 sum_reg  [CHANNELS];
    sum_t                 sum_next [CHANNELS];
    sample_t              out_avg_reg [CHANNELS];
    sample_t              div_quot [CHANNELS];
    logic                 div_done;

    logic [WIN_BITS-1:0]  eff_window;
    logic                 full;
    logic [WIN_BITS:0]    append_sum;
    logic [SLOT_BITS-1:0] append_slot;
    logic [WIN_BITS-1:0]  oldest_inc;
    logic [SLOT_BITS-1:0] oldest_next;
    logic [SLOT_BITS-1:0] accept_slot;
    logic                 in_accept;
    logic                 out_load;
    frame_t               in_frame;

    assign in_frame = {ch7_sample, ch6_sample, ch5_sample, ch4_sample,
                       ch3_sample, ch2_sample, ch1_sample, ch0_sample};

    // saturate the requested window to 1..MAX_WINDOW
    always_comb
    begin
        if (window_reg == '0)
            eff_window = WIN_BITS'(1);
        else if (window_reg > WIN_BITS'(MAX_WINDOW))
            eff_window = WIN_BITS'(MAX_WINDOW);
        else
            eff_window = window_reg;
    end

    assign full        = (frames_held_reg == eff_window);
    assign append_sum  = (WIN_BITS+1)'(oldest_reg) + (WIN_BITS+1)'(frames_held_reg);
    assign append_slot = (append_sum >= (WIN_BITS+1)'(eff_window))
                       ? SLOT_BITS'(append_sum - (WIN_BITS+1)'(eff_window))
                       : SLOT_BITS'(append_sum);
    assign oldest_inc  = WIN_BITS'(oldest_reg) + WIN_BITS'(1);
    assign oldest_next = (oldest_inc == eff_window) ? '0 : SLOT_BITS'(oldest_inc);
    // when full, the new frame overwrites the oldest one
    assign accept_slot = full ? oldest_reg : append_slot;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_load  = (((state_reg == ST_DIVIDE) && div_done) || (state_reg == ST_DELIVER))
                     && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            window_reg      <= WINDOW_RESET;
            frames_held_reg <= '0;
            oldest_reg      <= '0;
            full_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            div_req_reg     <= '0;
        end
        else
        begin
            div_req_reg.start <= (state_reg == ST_UPDATE);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            // a new window empties the ring
            if (cfg_write_en)
            begin
                window_reg      <= cfg_write_data;
                frames_held_reg <= '0;
                oldest_reg      <= '0;
            end
            else if (in_accept)
            begin
                if (full)
                    oldest_reg <= oldest_next;
                else
                    frames_held_reg <= frames_held_reg + WIN_BITS'(1);
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        full_reg  <= full;
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    div_req_reg.divisor <= frames_held_reg;
                    state_reg           <= ST_DIVIDE;
                end
                ST_DIVIDE:
                begin
                    if (out_load)
                        state_reg <= ST_IDLE;
                    else if (div_done)
                        state_reg <= ST_DELIVER;
                end
                ST_DELIVER:
                begin
                    if (out_load)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            slot_reg   <= accept_slot;
            sample_reg <= in_frame;
        end
        if (out_load)
            out_avg_reg <= div_quot;
    end

    // frame ring: read the slot at transfer, write the new frame to it in the cycle after
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPDATE)
            ring_mem[slot_reg] <= sample_reg;
        if (in_accept)
            ring_rd_reg <= ring_mem[accept_slot];
    end

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            // drop the oldest frame only when it is really being replaced
            sum_next[c] = sum_reg[c] + sext_sample(sample_reg[c])
                        - (full_reg ? sext_sample(ring_rd_reg[c]) : sum_t'(0));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
                sum_reg[c] <= '0;
        end
        else if (cfg_write_en)
        begin
            for (int c = 0; c < CHANNELS; c++)
                sum_reg[c] <= '0;
        end
        else if (state_reg == ST_UPDATE)
        begin
            sum_reg <= sum_next;
        end
    end

    mma_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .sums  (sum_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign out_valid   = out_valid_reg;
    assign ch0_average = out_avg_reg[0];
    assign ch1_average = out_avg_reg[1];
    assign ch2_average = out_avg_reg[2];
    assign ch3_average = out_avg_reg[3];
    assign ch4_average = out_avg_reg[4];
    assign ch5_average = out_avg_reg[5];
    assign ch6_average = out_avg_reg[6];
    assign ch7_average = out_avg_reg[7];

    `MMA_ASSERT_HOLDS(a_frames_bounded, 1'b1, frames_held_reg <= eff_window, "frame count above window")
    `MMA_ASSERT_HOLDS(a_oldest_only_full, oldest_reg != '0, frames_held_reg == eff_window, "oldest slot moved before ring full")
    `MMA_ASSERT_HOLDS(a_slot_in_window, state_reg == ST_UPDATE, slot_reg < SLOT_BITS'(eff_window) || eff_window == WIN_BITS'(MAX_WINDOW), "ring slot outside window")
    `MMA_ASSERT_HOLDS(a_done_in_divide, div_done, state_reg == ST_DIVIDE, "divider result outside divide state")
    `MMA_ASSERT_NEXT(a_stall_to_deliver, div_done && out_valid_reg && !out_ready, state_reg == ST_DELIVER, "blocked result not held")

endmodule
